// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TBO_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbo assertion failed");

// Next-cycle implication, disabled during reset
`define TBO_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbo assertion failed");

`endif

// ===== hw/rtl/tbo_pkg.sv =====
// Shared types, codes and the micro-op table of the triangle/box overlap core.
package tbo_pkg;

  // operand A sources
  localparam logic [1:0] OPA_ONE = 2'd0;
  localparam logic [1:0] OPA_E   = 2'd1;
  localparam logic [1:0] OPA_NH  = 2'd2;
  localparam logic [1:0] OPA_NL  = 2'd3;

  // operand B sources
  localparam logic [1:0] OPB_H = 2'd0;
  localparam logic [1:0] OPB_D = 2'd1;
  localparam logic [1:0] OPB_E = 2'd2;

  // actions on the finished accumulator
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_STR  = 2'd1;
  localparam logic [1:0] ACT_STN  = 2'd2;
  localparam logic [1:0] ACT_CMP  = 2'd3;

  localparam logic [3:0] AXIS_BND0 = 4'd9;
  localparam logic [3:0] AXIS_NRM  = 4'd12;

  typedef struct packed {
    logic       mac;
    logic       first;
    logic       sub;
    logic       absn;
    logic       shift;
    logic [1:0] a_sel;
    logic [1:0] a_v;
    logic [1:0] a_k;
    logic [1:0] b_sel;
    logic [1:0] b_v;
    logic [1:0] b_k;
    logic [1:0] act;
    logic       cmp_first;
    logic [1:0] st_k;
    logic       last;
  } uop_t;

  typedef struct packed {
    uop_t u;
    logic go;
  } ctrl_t;

  typedef struct packed {
    logic gt;
    logic lt;
  } cmp_t;

  // Micro-op for one step of one candidate axis.
  // Axes 0..8: edge crossed with box axis; 9..11: bounds; 12: plane.
  function automatic uop_t uop_at(input logic [3:0] axis, input logic [4:0] step);
    uop_t       u;
    logic [1:0] ei;
    logic [1:0] j;
    logic [1:0] k1;
    logic [1:0] k2;
    logic [1:0] kb;
    logic [1:0] vv;
    logic [1:0] nk;
    u  = '0;
    ei = (axis >= 4'd6) ? 2'd2 : ((axis >= 4'd3) ? 2'd1 : 2'd0);
    j  = 2'(axis - 4'({ei, 1'b0}) - 4'(ei));
    k1 = (j == 2'd2) ? 2'd0 : j + 2'd1;
    k2 = (j == 2'd0) ? 2'd2 : j - 2'd1;
    kb = 2'(axis - AXIS_BND0);
    vv = step[2:1] - 2'd1;
    nk = '0;
    if (axis < AXIS_BND0) begin
      u.a_sel = OPA_E;
      u.a_v   = ei;
      u.b_v   = vv;
      if (step == 5'd0) begin
        u.mac = 1'b1; u.first = 1'b1; u.absn = 1'b1;
        u.a_k = k2; u.b_sel = OPB_H; u.b_k = k1;
      end else if (step == 5'd1) begin
        u.mac = 1'b1; u.absn = 1'b1;
        u.a_k = k1; u.b_sel = OPB_H; u.b_k = k2;
      end else if (step == 5'd8) begin
        u.act = ACT_CMP; u.last = 1'b1;
      end else if (!step[0]) begin
        u.mac = 1'b1; u.first = 1'b1;
        u.a_k = k2; u.b_sel = OPB_D; u.b_k = k1;
        u.act = (step == 5'd2) ? ACT_STR : ACT_CMP;
        u.cmp_first = (step == 5'd4);
      end else begin
        u.mac = 1'b1; u.sub = 1'b1;
        u.a_k = k1; u.b_sel = OPB_D; u.b_k = k2;
      end
    end else if (axis < AXIS_NRM) begin
      u.a_sel = OPA_ONE;
      u.b_k   = kb;
      u.b_v   = 2'(step - 5'd1);
      if (step == 5'd0) begin
        u.mac = 1'b1; u.first = 1'b1; u.b_sel = OPB_H;
      end else if (step == 5'd4) begin
        u.act = ACT_CMP; u.last = 1'b1;
      end else begin
        u.mac = 1'b1; u.first = 1'b1; u.b_sel = OPB_D;
        u.act = (step == 5'd1) ? ACT_STR : ACT_CMP;
        u.cmp_first = (step == 5'd2);
      end
    end else begin
      if (step < 5'd6) begin
        // normal = e0 x (-e1), built one component at a time from two products
        u.a_sel = OPA_E; u.a_v = 2'd0;
        u.b_sel = OPB_E; u.b_v = 2'd1;
        u.mac   = 1'b1;
        u.first = !step[0];
        u.sub   = !step[0];
        u.act   = (step == 5'd2 || step == 5'd4) ? ACT_STN : ACT_NONE;
        u.st_k  = step[2:1] - 2'd1;
        unique case (step[2:0])
          3'd0:    begin u.a_k = 2'd1; u.b_k = 2'd2; end
          3'd1:    begin u.a_k = 2'd2; u.b_k = 2'd1; end
          3'd2:    begin u.a_k = 2'd2; u.b_k = 2'd0; end
          3'd3:    begin u.a_k = 2'd0; u.b_k = 2'd2; end
          3'd4:    begin u.a_k = 2'd0; u.b_k = 2'd1; end
          default: begin u.a_k = 2'd1; u.b_k = 2'd0; end
        endcase
      end else if (step < 5'd12) begin
        nk      = 2'((step - 5'd6) >> 1);
        u.mac   = 1'b1;
        u.absn  = 1'b1;
        u.first = (step == 5'd6);
        u.shift = !step[0];
        u.a_sel = step[0] ? OPA_NL : OPA_NH;
        u.a_k   = nk;
        u.b_sel = OPB_H;
        u.b_k   = nk;
        u.act   = (step == 5'd6) ? ACT_STN : ACT_NONE;
        u.st_k  = 2'd2;
      end else if (step < 5'd18) begin
        nk      = 2'((step - 5'd12) >> 1);
        u.mac   = 1'b1;
        u.first = (step == 5'd12);
        u.shift = !step[0];
        u.a_sel = step[0] ? OPA_NL : OPA_NH;
        u.a_k   = nk;
        u.b_sel = OPB_D;
        u.b_v   = 2'd0;
        u.b_k   = nk;
        u.act   = (step == 5'd12) ? ACT_STR : ACT_NONE;
      end else begin
        u.act = ACT_CMP; u.cmp_first = 1'b1; u.last = 1'b1;
      end
    end
    return u;
  endfunction

endpackage

// ===== hw/rtl/tbo_ifs.sv =====
// Valid/ready channel interfaces for the input and result transactions.
interface tbo_in_if #(parameter int COORD_BITS = 20);
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [1:0]                   vertex_slot;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic signed [COORD_BITS-1:0] vertex_z;
  logic signed [COORD_BITS-1:0] box_centre_x;
  logic signed [COORD_BITS-1:0] box_centre_y;
  logic signed [COORD_BITS-1:0] box_centre_z;
  logic [COORD_BITS-2:0]        box_half_x;
  logic [COORD_BITS-2:0]        box_half_y;
  logic [COORD_BITS-2:0]        box_half_z;
  modport source (output valid, action, vertex_slot, vertex_x, vertex_y, vertex_z,
                  box_centre_x, box_centre_y, box_centre_z,
                  box_half_x, box_half_y, box_half_z, input ready);
  modport sink (input valid, action, vertex_slot, vertex_x, vertex_y, vertex_z,
                box_centre_x, box_centre_y, box_centre_z,
                box_half_x, box_half_y, box_half_z, output ready);
endinterface

interface tbo_out_if;
  logic valid;
  logic ready;
  logic overlaps;
  modport source (output valid, overlaps, input ready);
  modport sink (input valid, overlaps, output ready);
endinterface

// ===== hw/rtl/triangle_box_overlap_sat_core.sv =====
// A box test walks the axes in turn: the edge axes, the bounds axes, then the plane.
// A separating axis ends the test early.
// Throughput: one box test at a time, set by the single shared multiply-accumulate unit.
// A vertex load gives no result; a new transaction is taken while
// a result waits. Synchronous active-low reset clears the triangle to zero and empties
// the result register.
module triangle_box_overlap_sat_core #(
  parameter int COORD_BITS = 20
) (
  input logic     clk,
  input logic     rst_n,
  tbo_in_if.sink  in_ch,
  tbo_out_if.source out_ch
);
  // Shared unit: each edge or bounds axis builds its projected radius first, then the
  // projection of every vertex, one product per cycle into a wide accumulator. Edge
  // axes are the triangle edges crossed with x, y and z; a zero axis gives zero
  // radius and zero projections, so it can never separate. Bounds axes reuse the path
  // with a unit operand. The plane axis builds its normal into three registers, fed
  // to the multiplier in high and low halves, then radius and one vertex projection.

  logic           accept;
  logic           ld_en;
  logic           box_en;
  logic           seq_ready;
  tbo_pkg::ctrl_t ctrl;
  tbo_pkg::cmp_t  cmp;

  assign accept = in_ch.valid & seq_ready;
  // drop loads aimed at the unused vertex slot
  assign ld_en  = accept & !in_ch.action & (in_ch.vertex_slot != 2'd3);
  assign box_en = accept & in_ch.action;
  assign in_ch.ready = seq_ready;

  tbo_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ld_en   (ld_en),
    .ld_slot (in_ch.vertex_slot),
    .ld_x    (in_ch.vertex_x),
    .ld_y    (in_ch.vertex_y),
    .ld_z    (in_ch.vertex_z),
    .box_en  (box_en),
    .box_cx  (in_ch.box_centre_x),
    .box_cy  (in_ch.box_centre_y),
    .box_cz  (in_ch.box_centre_z),
    .box_hx  (in_ch.box_half_x),
    .box_hy  (in_ch.box_half_y),
    .box_hz  (in_ch.box_half_z),
    .ctrl    (ctrl),
    .cmp     (cmp)
  );

  // Sequencer: advance axis by axis, hold on the last step if the result is unread
  tbo_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .test_go      (box_en),
    .in_ready     (seq_ready),
    .cmp          (cmp),
    .ctrl         (ctrl),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_overlaps (out_ch.overlaps)
  );

endmodule

// ===== hw/rtl/tbo_dp.sv =====
// Datapath: triangle and box store, operand select, shared multiply-accumulate, compare.
module tbo_dp #(
  parameter int COORD_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         ld_en,
  input  logic [1:0]                   ld_slot,
  input  logic signed [COORD_BITS-1:0] ld_x,
  input  logic signed [COORD_BITS-1:0] ld_y,
  input  logic signed [COORD_BITS-1:0] ld_z,
  input  logic                         box_en,
  input  logic signed [COORD_BITS-1:0] box_cx,
  input  logic signed [COORD_BITS-1:0] box_cy,
  input  logic signed [COORD_BITS-1:0] box_cz,
  input  logic [COORD_BITS-2:0]        box_hx,
  input  logic [COORD_BITS-2:0]        box_hy,
  input  logic [COORD_BITS-2:0]        box_hz,
  input  tbo_pkg::ctrl_t               ctrl,
  output tbo_pkg::cmp_t                cmp
);
  localparam int CW = COORD_BITS;
  localparam int MW = CW + 2;
  localparam int SH = CW + 1;
  localparam int NW = 2 * CW + 3;
  localparam int AW = 3 * CW + 5;
  localparam int PW = 2 * MW;

  logic signed [CW-1:0] tri_r [3][3];
  logic signed [CW-1:0] ctr_r [3];
  logic [CW-2:0]        hlf_r [3];
  logic signed [NW-1:0] nrm_r [3];
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] rad_r;
  logic signed [AW-1:0] acc_nxt;

  logic signed [CW:0]   e_w [3][3];
  logic signed [CW:0]   d_w [3][3];
  logic signed [MW-1:0] opa;
  logic signed [MW-1:0] opb;
  logic                 a_neg;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] pext;
  logic signed [AW-1:0] psh;
  logic signed [AW-1:0] term;
  logic signed [AW-1:0] base;
  tbo_pkg::uop_t        u;

  assign u = ctrl.u;

  // edges v[i+1]-v[i] and offsets v[i]-centre, each at a fixed place
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        e_w[i][k] = $signed({tri_r[(i == 2) ? 0 : i + 1][k][CW-1],
                             tri_r[(i == 2) ? 0 : i + 1][k]})
                  - $signed({tri_r[i][k][CW-1], tri_r[i][k]});
        d_w[i][k] = $signed({tri_r[i][k][CW-1], tri_r[i][k]})
                  - $signed({ctr_r[k][CW-1], ctr_r[k]});
      end
    end
  end

  always_comb begin
    unique case (u.a_sel)
      tbo_pkg::OPA_ONE: begin
        opa   = $signed({{(MW-1){1'b0}}, 1'b1});
        a_neg = 1'b0;
      end
      tbo_pkg::OPA_E: begin
        opa   = $signed({e_w[u.a_v][u.a_k][CW], e_w[u.a_v][u.a_k]});
        a_neg = e_w[u.a_v][u.a_k][CW];
      end
      tbo_pkg::OPA_NH: begin
        opa   = $signed(nrm_r[u.a_k][NW-1:SH]);
        a_neg = nrm_r[u.a_k][NW-1];
      end
      default: begin
        opa   = $signed({1'b0, nrm_r[u.a_k][SH-1:0]});
        a_neg = nrm_r[u.a_k][NW-1];
      end
    endcase
    unique case (u.b_sel)
      tbo_pkg::OPB_H: opb = $signed({3'b000, hlf_r[u.b_k]});
      tbo_pkg::OPB_D: opb = $signed({d_w[u.b_v][u.b_k][CW], d_w[u.b_v][u.b_k]});
      tbo_pkg::OPB_E: opb = $signed({e_w[u.b_v][u.b_k][CW], e_w[u.b_v][u.b_k]});
      default:        opb = '0;
    endcase
  end

  // shared multiply-accumulate; high half of the normal is weighted by 2^SH
  always_comb begin
    prod    = opa * opb;
    pext    = $signed({{(AW-PW){prod[PW-1]}}, prod});
    psh     = u.shift ? (pext <<< SH) : pext;
    term    = (u.sub ^ (u.absn & a_neg)) ? -psh : psh;
    base    = u.first ? '0 : acc_r;
    acc_nxt = base + term;
  end

  assign cmp.gt = (acc_r > rad_r);
  assign cmp.lt = (acc_r < -rad_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          tri_r[i][k] <= '0;
        end
      end
    end else if (ld_en) begin
      tri_r[ld_slot][0] <= ld_x;
      tri_r[ld_slot][1] <= ld_y;
      tri_r[ld_slot][2] <= ld_z;
    end
  end

  always_ff @(posedge clk) begin
    if (box_en) begin
      ctr_r[0] <= box_cx;
      ctr_r[1] <= box_cy;
      ctr_r[2] <= box_cz;
      hlf_r[0] <= box_hx;
      hlf_r[1] <= box_hy;
      hlf_r[2] <= box_hz;
    end
    if (ctrl.go && u.mac) begin
      acc_r <= acc_nxt;
    end
    if (ctrl.go && u.act == tbo_pkg::ACT_STR) begin
      rad_r <= acc_r;
    end
    if (ctrl.go && u.act == tbo_pkg::ACT_STN) begin
      nrm_r[u.st_k] <= acc_r[NW-1:0];
    end
  end

endmodule

// ===== hw/rtl/tbo_seq.sv =====
// Sequencer: walks axes and steps, folds compare flags, holds the result register.
module tbo_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           test_go,
  output logic           in_ready,
  input  tbo_pkg::cmp_t  cmp,
  output tbo_pkg::ctrl_t ctrl,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_overlaps
);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic          state_r;
  logic [3:0]    axis_r;
  logic [4:0]    step_r;
  logic          gt_r;
  logic          lt_r;
  logic          ov_r;
  logic          res_r;
  tbo_pkg::uop_t u;
  logic          run;
  logic          gt_now;
  logic          lt_now;
  logic          sep;
  logic          finish;
  logic          go;

  always_comb begin
    u      = tbo_pkg::uop_at(axis_r, step_r);
    run    = (state_r == ST_RUN);
    gt_now = (u.cmp_first | gt_r) & cmp.gt;
    lt_now = (u.cmp_first | lt_r) & cmp.lt;
    sep    = gt_now | lt_now;
    finish = run & u.last & (sep | (axis_r == tbo_pkg::AXIS_NRM));
    // hold on the final step while the result register is full and not being read
    go     = run & !(finish & ov_r & !out_ready);
  end

  assign ctrl.u       = u;
  assign ctrl.go      = go;
  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = ov_r;
  assign out_overlaps = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= '0;
      step_r  <= '0;
      gt_r    <= 1'b0;
      lt_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (test_go) begin
            state_r <= ST_RUN;
            axis_r  <= '0;
            step_r  <= '0;
          end
        end
        default: begin
          if (go) begin
            if (finish) begin
              state_r <= ST_IDLE;
            end else if (u.last) begin
              axis_r <= axis_r + 4'd1;
              step_r <= '0;
            end else begin
              step_r <= step_r + 5'd1;
            end
            if (u.act == tbo_pkg::ACT_CMP) begin
              gt_r <= gt_now;
              lt_r <= lt_now;
            end
          end
        end
      endcase
      if (go && finish) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && finish) begin
      res_r <= !sep;
    end
  end

endmodule

// ===== hw/rtl/tbo_chk.sv =====
// Port-level checker for the overlap core, bound to the top level.
`include "assert_macros.svh"

module tbo_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_action,
  input logic out_valid,
  input logic out_ready
);
  // a box test occupies the core
  `TBO_ASSERT_NXT(a_test_busy, clk, rst_n, in_valid && in_ready && in_action, !in_ready)
  // a vertex load leaves the core free
  `TBO_ASSERT_NXT(a_load_free, clk, rst_n, in_valid && in_ready && !in_action, in_ready)
  // a new result only comes out of a running test
  `TBO_ASSERT_IMP(a_res_from_run, clk, rst_n, $rose(out_valid), $past(!in_ready) && in_ready)
  // hold an unread result
  `TBO_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind triangle_box_overlap_sat_core tbo_chk u_tbo_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
